>>> rtl/core/tksd_pkg.sv
package tksd_pkg;

    localparam int MOUSE_MAX_DEF = 30;
    localparam int COUNT_W       = 5;
    localparam int ACCUM_W       = 8;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;
    localparam logic [7:0] CH_MOUSE_PRESS   = 8'h4D;
    localparam logic [7:0] CH_MOUSE_RELEASE = 8'h6D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic [ACCUM_W-1:0] BTN_SCROLL_UP   = 8'd64;
    localparam logic [ACCUM_W-1:0] BTN_SCROLL_DOWN = 8'd65;
    localparam logic [ACCUM_W-1:0] ACCUM_SAT       = 8'd255;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_CSI   = 3'd2,
        PH_MOUSE = 3'd3,
        PH_SKIP  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_CHAR   = 3'd1,
        K_ESCAPE = 3'd2,
        K_UP     = 3'd3,
        K_DOWN   = 3'd4,
        K_RIGHT  = 3'd5,
        K_LEFT   = 3'd6,
        K_SCRUP  = 3'd7
    } t_kind;

    typedef struct packed {
        t_phase               phase;
        logic [COUNT_W-1:0]   mouse_count;
        logic [ACCUM_W-1:0]   button_accum;
        logic                 separator_seen;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic       scroll_down;
        logic [7:0] ch;
    } t_key;

    typedef struct packed {
        logic emit;
        t_key key;
    } t_result;

endpackage

>>> rtl/core/tksd_decode.sv
module tksd_decode #(
    parameter int MOUSE_MAX = tksd_pkg::MOUSE_MAX_DEF
) (
    input  tksd_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_none,
    output tksd_pkg::t_state  o_state,
    output tksd_pkg::t_result o_result
);

    localparam logic [tksd_pkg::COUNT_W-1:0] COUNT_END = MOUSE_MAX[tksd_pkg::COUNT_W-1:0];

    logic                            is_digit;
    logic [tksd_pkg::COUNT_W-1:0]    count_inc;
    logic [11:0]                     accum_sum;
    logic [tksd_pkg::ACCUM_W-1:0]    accum_sat;
    logic [tksd_pkg::ACCUM_W-1:0]    accum_next;
    logic                            sep_next;
    tksd_pkg::t_kind                 mouse_kind;
    logic                            mouse_down;

    assign is_digit  = (i_byte >= tksd_pkg::CH_ZERO) && (i_byte <= tksd_pkg::CH_NINE);
    assign count_inc = i_state.mouse_count + 1'b1;
    assign accum_sum = {4'd0, i_state.button_accum} * 12'd10 + {4'd0, i_byte - tksd_pkg::CH_ZERO};
    assign accum_sat = (accum_sum > 12'd255) ? tksd_pkg::ACCUM_SAT : accum_sum[7:0];

    // The button number is only taken from digits ahead of the first separator.
    always_comb begin
        sep_next   = i_state.separator_seen;
        accum_next = i_state.button_accum;
        if (i_byte == tksd_pkg::CH_SEMI) begin
            sep_next = 1'b1;
        end else if (!i_state.separator_seen && is_digit) begin
            accum_next = accum_sat;
        end
    end

    // A finished report is judged on the button value after this byte is counted.
    always_comb begin
        logic [tksd_pkg::ACCUM_W-1:0] btn;
        btn = i_none ? i_state.button_accum : accum_next;
        mouse_kind = tksd_pkg::K_NONE;
        mouse_down = 1'b0;
        if (btn == tksd_pkg::BTN_SCROLL_UP) begin
            mouse_kind = tksd_pkg::K_SCRUP;
        end else if (btn == tksd_pkg::BTN_SCROLL_DOWN) begin
            mouse_down = 1'b1;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_state.phase)
            tksd_pkg::PH_ESC: begin
                if (i_none || i_byte != tksd_pkg::CH_LBRACK) begin
                    o_result.emit     = 1'b1;
                    o_result.key.kind = tksd_pkg::K_ESCAPE;
                end else begin
                    o_state.phase = tksd_pkg::PH_CSI;
                end
            end
            tksd_pkg::PH_CSI: begin
                o_result.emit = 1'b1;
                if (i_none) begin
                    o_result.key.kind = tksd_pkg::K_ESCAPE;
                end else begin
                    case (i_byte)
                        tksd_pkg::CH_UP:    o_result.key.kind = tksd_pkg::K_UP;
                        tksd_pkg::CH_DOWN:  o_result.key.kind = tksd_pkg::K_DOWN;
                        tksd_pkg::CH_RIGHT: o_result.key.kind = tksd_pkg::K_RIGHT;
                        tksd_pkg::CH_LEFT:  o_result.key.kind = tksd_pkg::K_LEFT;
                        tksd_pkg::CH_LT: begin
                            o_result.emit          = 1'b0;
                            o_state.phase          = tksd_pkg::PH_MOUSE;
                            o_state.mouse_count    = '0;
                            o_state.button_accum   = '0;
                            o_state.separator_seen = 1'b0;
                        end
                        default: begin
                            if (is_digit) begin
                                o_result.emit = 1'b0;
                                o_state.phase = tksd_pkg::PH_SKIP;
                            end
                        end
                    endcase
                end
            end
            tksd_pkg::PH_MOUSE: begin
                if (!i_none) begin
                    o_state.mouse_count    = count_inc;
                    o_state.button_accum   = accum_next;
                    o_state.separator_seen = sep_next;
                end
                if (i_none || i_byte == tksd_pkg::CH_MOUSE_PRESS
                        || i_byte == tksd_pkg::CH_MOUSE_RELEASE || count_inc >= COUNT_END) begin
                    o_result.emit            = 1'b1;
                    o_result.key.kind        = mouse_kind;
                    o_result.key.scroll_down = mouse_down;
                end
            end
            tksd_pkg::PH_SKIP: begin
                if (i_none || i_byte == tksd_pkg::CH_TILDE
                        || i_byte inside {[tksd_pkg::CH_UPPER_A:tksd_pkg::CH_UPPER_Z]}) begin
                    o_result.emit = 1'b1;
                end
            end
            default: begin
                if (i_none) begin
                    o_result.emit = 1'b1;
                end else if (i_byte == tksd_pkg::CH_ESC) begin
                    o_state.phase = tksd_pkg::PH_ESC;
                end else begin
                    o_result.emit     = 1'b1;
                    o_result.key.kind = tksd_pkg::K_CHAR;
                    o_result.key.ch   = i_byte;
                end
            end
        endcase
        if (o_result.emit) begin
            o_state.phase = tksd_pkg::PH_IDLE;
        end
    end

endmodule

>>> rtl/core/tksd_out_stage.sv
module tksd_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  tksd_pkg::t_key i_key,
    input  logic          i_ready,
    output logic          o_valid,
    output tksd_pkg::t_key o_key,
    output logic          o_free
);

    logic           r_valid;
    tksd_pkg::t_key r_key;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_key   = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end
    end

endmodule

>>> rtl/core/terminal_key_sequence_decoder_unit.sv
// Terminal key sequence decoder.
// The slave stream carries one terminal byte per transaction: s_axis_tdata is the
// byte and s_axis_tuser is the no-data flag of a poll that found nothing to read.
// The master stream carries one key event per transaction: m_axis_tdata holds the
// character for char events, and tuser holds the key kind and the scroll-down flag.
// Bytes inside an escape or CSI sequence that do not complete it produce no event.
// An accepted byte is held in an input register and decoded against the sequence
// state, and its event is loaded into the output register, from which it is offered.
// Throughput is one byte per cycle unless an event waits for the output register;
// the only feedback path is the update of the sequence state (phase, mouse byte
// count, button number, separator flag).
// While the receiver stalls, the output register holds its event and the input
// register can still take a byte; a byte that produces an event then waits there, and
// s_axis_tready drops until the output register frees.
// A synchronous active-low reset empties both registers and returns the decoder to
// the idle phase with the mouse report state cleared.
module terminal_key_sequence_decoder_unit #(
    parameter int MOUSE_MAX = tksd_pkg::MOUSE_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] no_data
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] key_char
    output logic [3:0] m_axis_tuser    // [2:0] key_kind, [3] key_is_scroll_down
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_none;
    tksd_pkg::t_state  r_state;
    tksd_pkg::t_state  n_state;
    tksd_pkg::t_result step;
    tksd_pkg::t_key    out_key;
    logic              out_free;
    logic              advance;
    logic              in_accept;

    tksd_decode #(
        .MOUSE_MAX(MOUSE_MAX)
    ) u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_none  (r_in_none),
        .o_state (n_state),
        .o_result(step)
    );

    assign advance       = r_in_valid && (!step.emit || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '{phase: tksd_pkg::PH_IDLE, mouse_count: '0,
                            button_accum: '0, separator_seen: 1'b0};
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_none <= s_axis_tuser;
        end
    end

    tksd_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (advance && step.emit),
        .i_key  (step.key),
        .i_ready(m_axis_tready),
        .o_valid(m_axis_tvalid),
        .o_key  (out_key),
        .o_free (out_free)
    );

    assign m_axis_tdata = out_key.ch;
    assign m_axis_tuser = {out_key.scroll_down, out_key.kind};

endmodule

>>> rtl/core/tksd_checker.sv
module tksd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser
);

    // Both registers are empty right after reset, so the input side is ready.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not empty right after reset");

    // Only a char event carries a nonzero character.
    a_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != tksd_pkg::K_CHAR |-> m_axis_tdata == 8'd0)
        else $error("character byte on a non-char event");

    // A scroll-down event reads as kind none.
    a_scroll_down_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == tksd_pkg::K_NONE)
        else $error("scroll down with a nonzero kind");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("event dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("event changed while stalled");

endmodule

bind terminal_key_sequence_decoder_unit tksd_checker u_tksd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
